// ===== rtl/fhtc_pkg.sv =====
// ----------------------------------------------------------------------------
// fhtc_pkg
// Shared types, constants and step table for the file header type classifier.
// ----------------------------------------------------------------------------
package fhtc_pkg;

  localparam int WINDOW_BYTES = 1024;
  localparam int ADDR_W       = $clog2(WINDOW_BYTES);
  localparam int CNT_W        = $clog2(WINDOW_BYTES + 1);

  // read steps: offset bytes, leading header bytes, then bytes relative to offset
  localparam int NSTEP    = 19;
  localparam int STEP_W   = $clog2(NSTEP + 1);
  localparam int SLOT_W   = $clog2(NSTEP);
  localparam int STEP_HDR = 4;
  localparam int STEP_PE  = 11;
  localparam int STEP_MF  = 15;
  localparam int STEP_CH  = 17;
  localparam int DISP_W   = 6;

  localparam logic [2:0] CLS_OTHER = 3'd0;
  localparam logic [2:0] CLS_ZIP   = 3'd1;
  localparam logic [2:0] CLS_RAR   = 3'd2;
  localparam logic [2:0] CLS_ELF   = 3'd3;
  localparam logic [2:0] CLS_EXE   = 3'd4;
  localparam logic [2:0] CLS_DLL   = 3'd5;

  localparam logic [31:0] ZIP_SIG = 32'h0403_4B50;
  localparam logic [55:0] RAR_SIG = 56'h00_071A_2172_6152;
  localparam logic [55:0] ELF_SIG = 56'h01_0101_464C_457F;
  localparam logic [15:0] MZ_SIG  = 16'h5A4D;
  localparam logic [31:0] PE_SIG  = 32'h0000_4550;
  localparam logic [15:0] NE_SIG  = 16'h454E;

  localparam int          PE_SPAN     = 24;
  localparam int          PE_DLL_BIT  = 13;
  localparam int          PE_EXE_BIT  = 1;
  localparam logic [15:0] NE_DLL_MASK = 16'h8001;

  typedef struct packed {
    logic [7:0] header_byte;
    logic       last_byte;
  } hdr_item_t;

  typedef struct packed {
    logic [2:0] file_class;
    logic       offset_out_of_window;
  } cls_item_t;

  typedef struct packed {
    logic              en;
    logic [CNT_W-1:0]  base;
    logic [DISP_W-1:0] disp;
  } rd_req_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_FETCH,
    SEQ_DECIDE
  } seq_state_t;

  function automatic logic [DISP_W-1:0] step_disp(input logic [SLOT_W-1:0] s);
    logic [DISP_W-1:0] d;
    d = DISP_W'(s);
    if (s < SLOT_W'(STEP_HDR)) begin
      d = DISP_W'(60) + DISP_W'(s);
    end else if (s < SLOT_W'(STEP_PE)) begin
      d = DISP_W'(s) - DISP_W'(STEP_HDR);
    end else if (s < SLOT_W'(STEP_MF)) begin
      d = DISP_W'(s) - DISP_W'(STEP_PE);
    end else if (s < SLOT_W'(STEP_CH)) begin
      d = DISP_W'(s) - DISP_W'(3);
    end else begin
      d = DISP_W'(s) + DISP_W'(5);
    end
    return d;
  endfunction

endpackage

// ===== rtl/file_header_type_classifier.sv =====
// ----------------------------------------------------------------------------
// file_header_type_classifier
// Collects leading file bytes into a header window and classifies the file
// (ZIP, RAR, ELF, PE/NE EXE or DLL) when the last byte arrives.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  hdr      hdr_valid/hdr_stall   hdr_item_t: header_byte, last_byte
//  cls      cls_valid/cls_stall   cls_item_t: file_class, offset_out_of_window
//
//  A byte without the last mark raises no stall.
//  A last byte starts 19 window reads, one per cycle through the single read
//  port, then a decode: hdr_stall stays high through both plus any wait on cls.
//  The result sits in an output register; cls_stall holds it.
//  Reset is synchronous; no clearing pass over the window is needed.
// ----------------------------------------------------------------------------
module file_header_type_classifier (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  hdr_valid,
  output logic                  hdr_stall,
  input  fhtc_pkg::hdr_item_t   hdr,
  output logic                  cls_valid,
  input  logic                  cls_stall,
  output fhtc_pkg::cls_item_t   cls
);

  logic                  hdr_take;
  logic                  busy;
  logic                  done;
  logic                  clear;
  logic                  load_ok;
  logic [7:0]            rd_byte;
  fhtc_pkg::rd_req_t     req;
  fhtc_pkg::cls_item_t   result;

  assign hdr_stall = busy;
  assign hdr_take  = hdr_valid && !busy;
  assign load_ok   = !cls_valid || !cls_stall;

  fhtc_window u_window (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (hdr_take),
    .wr_byte (hdr.header_byte),
    .clear   (clear),
    .req     (req),
    .rd_byte (rd_byte)
  );

  fhtc_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (hdr_take && hdr.last_byte),
    .load_ok (load_ok),
    .rd_byte (rd_byte),
    .req     (req),
    .busy    (busy),
    .done    (done),
    .clear   (clear),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cls_valid <= 1'b0;
    end else if (done) begin
      cls_valid <= 1'b1;
    end else if (!cls_stall) begin
      cls_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      cls <= result;
    end
  end

  a_done_has_room: assert property (@(posedge clk) disable iff (rst)
    done |-> (!cls_valid || !cls_stall))
    else $error("result loaded over an untaken transaction");

  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    hdr_valid && !hdr_stall && hdr.last_byte |=> hdr_stall)
    else $error("input not stalled after last byte");

  a_done_shows: assert property (@(posedge clk) disable iff (rst)
    done |=> cls_valid)
    else $error("loaded result not presented");

  a_no_done_while_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> hdr_stall)
    else $error("result produced while sequencer idle");

endmodule

// ===== rtl/fhtc_window.sv =====
// ----------------------------------------------------------------------------
// fhtc_window
// Header byte store with fill count, and the shared position adder and
// bounds compare used for every read. Positions past the fill read as zero.
// ----------------------------------------------------------------------------
module fhtc_window (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [7:0]            wr_byte,
  input  logic                  clear,
  input  fhtc_pkg::rd_req_t     req,
  output logic [7:0]            rd_byte
);

  logic [7:0]                 mem [fhtc_pkg::WINDOW_BYTES];
  logic [fhtc_pkg::CNT_W-1:0] count;
  logic [fhtc_pkg::CNT_W-1:0] pos;
  logic                       room;
  logic [7:0]                 rd_q;
  logic                       zero_q;

  assign room = count < fhtc_pkg::CNT_W'(fhtc_pkg::WINDOW_BYTES);
  assign pos  = req.base + fhtc_pkg::CNT_W'(req.disp);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      count <= '0;
    end else if (wr_en && room) begin
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && room) begin
      mem[count[fhtc_pkg::ADDR_W-1:0]] <= wr_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (req.en) begin
      rd_q   <= mem[pos[fhtc_pkg::ADDR_W-1:0]];
      zero_q <= pos >= count;
    end
  end

  assign rd_byte = zero_q ? 8'h00 : rd_q;

endmodule

// ===== rtl/fhtc_seq.sv =====
// ----------------------------------------------------------------------------
// fhtc_seq
// Read sequencer: walks the step table through the window, collects the
// bytes, then decodes the header class.
// ----------------------------------------------------------------------------
module fhtc_seq (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   load_ok,
  input  logic [7:0]             rd_byte,
  output fhtc_pkg::rd_req_t      req,
  output logic                   busy,
  output logic                   done,
  output logic                   clear,
  output fhtc_pkg::cls_item_t    result
);

  fhtc_pkg::seq_state_t        state, state_next;
  logic [fhtc_pkg::STEP_W-1:0] step, step_next;
  logic                        cap_valid;
  logic [fhtc_pkg::SLOT_W-1:0] cap_idx;
  logic [7:0]                  slot [fhtc_pkg::NSTEP];
  logic                        issue;

  logic [31:0] off;
  logic [55:0] hdr;
  logic [32:0] span_end;
  logic [15:0] ch;
  logic [15:0] mf;
  logic        oow;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fhtc_pkg::SEQ_IDLE;
      step      <= '0;
      cap_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      cap_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    cap_idx <= step[fhtc_pkg::SLOT_W-1:0];
    if (cap_valid) begin
      slot[cap_idx] <= rd_byte;
    end
  end

  assign off = {slot[3], slot[2], slot[1], slot[0]};
  assign hdr = {slot[10], slot[9], slot[8], slot[7], slot[6], slot[5], slot[4]};
  assign mf  = {slot[16], slot[15]};
  assign ch  = {slot[18], slot[17]};

  assign issue    = (state == fhtc_pkg::SEQ_FETCH) &&
                    (step < fhtc_pkg::STEP_W'(fhtc_pkg::NSTEP));
  assign req.en   = issue;
  assign req.disp = fhtc_pkg::step_disp(step[fhtc_pkg::SLOT_W-1:0]);
  assign req.base = (step >= fhtc_pkg::STEP_W'(fhtc_pkg::STEP_PE)) ?
                    off[fhtc_pkg::CNT_W-1:0] : '0;

  assign span_end = {1'b0, off} + 33'(fhtc_pkg::PE_SPAN);
  assign oow      = span_end > 33'(fhtc_pkg::WINDOW_BYTES);

  always_comb begin
    result.file_class           = fhtc_pkg::CLS_OTHER;
    result.offset_out_of_window = 1'b0;
    priority if (hdr[31:0] == fhtc_pkg::ZIP_SIG) begin
      result.file_class = fhtc_pkg::CLS_ZIP;
    end else if (hdr == fhtc_pkg::RAR_SIG) begin
      result.file_class = fhtc_pkg::CLS_RAR;
    end else if (hdr == fhtc_pkg::ELF_SIG) begin
      result.file_class = fhtc_pkg::CLS_ELF;
    end else if (hdr[15:0] != fhtc_pkg::MZ_SIG) begin
      result.file_class = fhtc_pkg::CLS_OTHER;
    end else if (oow) begin
      result.offset_out_of_window = 1'b1;
    end else if ({slot[14], slot[13], slot[12], slot[11]} == fhtc_pkg::PE_SIG) begin
      if (ch[fhtc_pkg::PE_DLL_BIT]) begin
        result.file_class = fhtc_pkg::CLS_DLL;
      end else if (ch[fhtc_pkg::PE_EXE_BIT]) begin
        result.file_class = fhtc_pkg::CLS_EXE;
      end
    end else if ({slot[12], slot[11]} == fhtc_pkg::NE_SIG) begin
      result.file_class = ((mf & fhtc_pkg::NE_DLL_MASK) == fhtc_pkg::NE_DLL_MASK) ?
                          fhtc_pkg::CLS_DLL : fhtc_pkg::CLS_EXE;
    end else begin
      result.file_class = fhtc_pkg::CLS_OTHER;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    done       = 1'b0;
    clear      = 1'b0;
    unique case (state)
      fhtc_pkg::SEQ_IDLE: begin
        step_next = '0;
        if (start) begin
          state_next = fhtc_pkg::SEQ_FETCH;
        end
      end
      fhtc_pkg::SEQ_FETCH: begin
        if (step == fhtc_pkg::STEP_W'(fhtc_pkg::NSTEP)) begin
          state_next = fhtc_pkg::SEQ_DECIDE;
        end else begin
          step_next = step + 1'b1;
        end
      end
      fhtc_pkg::SEQ_DECIDE: begin
        if (load_ok) begin
          done       = 1'b1;
          clear      = 1'b1;
          state_next = fhtc_pkg::SEQ_IDLE;
        end
      end
      default: begin
        state_next = fhtc_pkg::SEQ_IDLE;
      end
    endcase
  end

  assign busy = state != fhtc_pkg::SEQ_IDLE;

endmodule
